[rtl/message_tag_match_table_top_assert.svh]
// Assertion macros for the tag match table.
`ifndef MESSAGE_TAG_MATCH_TABLE_TOP_ASSERT_SVH
`define MESSAGE_TAG_MATCH_TABLE_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define MTMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define MTMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/mtmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mtmt_pkg;

  localparam logic [1:0] MODE_INS_LIB  = 2'd0;
  localparam logic [1:0] MODE_INS_USER = 2'd1;
  localparam logic [1:0] MODE_FIND     = 2'd2;
  localparam logic [1:0] MODE_INVAL    = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NOMATCH = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  localparam int unsigned OCC_W   = 7;
  localparam logic [6:0]  OCC_MAX = 7'd127;

  typedef struct packed {
    logic [30:0] count;
    logic [7:0]  dtype;
    logic [31:0] buffer;
  } pay_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

endpackage
`default_nettype wire

[rtl/message_tag_match_table_top.sv]
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_ready   | mode, buffer_handle, element_count,
//         |           |                     | datatype_code, msg_tag, any_tag,
//         |           |                     | comm_id, slot
// output  | out       | out_valid/out_ready | status, slot_index, release_buffer,
//         |           |                     | released_handle
//
// A transaction is accepted in S_IDLE, which registers the per-entry match
// vector and the payload memory read; S_EVAL then priority-encodes and
// writes back. Reset clears valid bits and occupancy with no sweep.
// A stalled output holds S_EVAL; a new transaction is accepted while
// a result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "message_tag_match_table_top_assert.svh"
module message_tag_match_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] buffer_handle,
  input  wire logic [30:0] element_count,
  input  wire logic [7:0]  datatype_code,
  input  wire logic [14:0] msg_tag,
  input  wire logic        any_tag,
  input  wire logic [7:0]  comm_id,
  input  wire logic [7:0]  slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [5:0]       slot_index,
  output logic             release_buffer,
  output logic [31:0]      released_handle
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  function automatic logic [IDX_W-1:0] first_set(input logic [TABLE_ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = IDX_W'(i);
      end
    end
    return r;
  endfunction

  mtmt_pkg::state_t state;
  mtmt_pkg::state_t state_next;

  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [TABLE_ENTRIES-1:0] entry_user_owned;
  logic [14:0]              entry_tag [TABLE_ENTRIES];
  logic [7:0]               entry_comm [TABLE_ENTRIES];
  logic [mtmt_pkg::OCC_W-1:0] occupied_count;

  mtmt_pkg::pay_t pay_mem [TABLE_ENTRIES];
  logic [31:0]    rd_buffer;

  logic [1:0]  mode_q;
  logic [31:0] buffer_q;
  logic [30:0] count_q;
  logic [7:0]  dtype_q;
  logic [14:0] tag_q;
  logic [7:0]  comm_q;
  logic [7:0]  slot_q;
  logic [TABLE_ENTRIES-1:0] match_vec;

  logic                 in_fire;
  logic                 eval_fire;
  logic                 found;
  logic [IDX_W-1:0]     win_idx;
  logic [IDX_W-1:0]     slot_idx;
  logic                 is_insert;
  logic                 in_range;
  logic                 res_release;
  logic [1:0]           res_status;
  logic [7:0]           res_idx;
  logic [31:0]          res_handle;
  logic                 do_insert;
  logic                 do_clear;
  logic [TABLE_ENTRIES-1:0] match_next;

  assign in_ready  = (state == mtmt_pkg::S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign eval_fire = (state == mtmt_pkg::S_EVAL) && (!out_valid || out_ready);

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      case (mode)
        mtmt_pkg::MODE_INS_LIB, mtmt_pkg::MODE_INS_USER: match_next[i] = !entry_valid[i];
        mtmt_pkg::MODE_FIND: match_next[i] = entry_valid[i] && (entry_comm[i] == comm_id) &&
                                             (any_tag || (entry_tag[i] == msg_tag));
        default: match_next[i] = 1'b0;
      endcase
    end
  end

  assign found     = |match_vec;
  assign win_idx   = first_set(match_vec);
  assign slot_idx  = slot_q[IDX_W-1:0];
  assign is_insert = (mode_q == mtmt_pkg::MODE_INS_LIB) || (mode_q == mtmt_pkg::MODE_INS_USER);
  assign in_range  = ({1'b0, slot_q} < 9'(TABLE_ENTRIES));

  always_comb begin
    res_status  = mtmt_pkg::ST_OK;
    res_idx     = '0;
    res_release = 1'b0;
    case (mode_q)
      mtmt_pkg::MODE_INS_LIB, mtmt_pkg::MODE_INS_USER: begin
        res_status = found ? mtmt_pkg::ST_OK : mtmt_pkg::ST_FULL;
        res_idx    = found ? 8'(win_idx) : 8'd0;
      end
      mtmt_pkg::MODE_FIND: begin
        res_status = found ? mtmt_pkg::ST_OK : mtmt_pkg::ST_NOMATCH;
        res_idx    = found ? 8'(win_idx) : 8'd0;
      end
      default: begin
        res_status  = in_range ? mtmt_pkg::ST_OK : mtmt_pkg::ST_RANGE;
        res_idx     = in_range ? slot_q : 8'd0;
        res_release = in_range && entry_valid[slot_idx] && !entry_user_owned[slot_idx];
      end
    endcase
  end

  assign res_handle = res_release ? rd_buffer : 32'd0;
  assign do_insert  = eval_fire && is_insert && found;
  assign do_clear   = eval_fire && (mode_q == mtmt_pkg::MODE_INVAL) && in_range &&
                      entry_valid[slot_idx];

  always_comb begin
    state_next = state;
    case (state)
      mtmt_pkg::S_IDLE: if (in_fire) state_next = mtmt_pkg::S_EVAL;
      mtmt_pkg::S_EVAL: if (eval_fire) state_next = mtmt_pkg::S_IDLE;
      default: state_next = mtmt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mtmt_pkg::S_IDLE;
      entry_valid    <= '0;
      entry_user_owned <= '0;
      occupied_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (do_insert) begin
        entry_valid[win_idx]      <= 1'b1;
        entry_user_owned[win_idx] <= mode_q[0];
        if (occupied_count < mtmt_pkg::OCC_MAX) occupied_count <= occupied_count + 7'd1;
      end
      if (do_clear) begin
        entry_valid[slot_idx]      <= 1'b0;
        entry_user_owned[slot_idx] <= 1'b0;
        if (occupied_count != '0) occupied_count <= occupied_count - 7'd1;
      end
      if (eval_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q    <= mode;
      buffer_q  <= buffer_handle;
      count_q   <= element_count;
      dtype_q   <= datatype_code;
      tag_q     <= msg_tag;
      comm_q    <= comm_id;
      slot_q    <= slot;
      match_vec <= match_next;
    end
    if (eval_fire) begin
      status          <= res_status;
      slot_index      <= res_idx[5:0];
      release_buffer  <= res_release;
      released_handle <= res_handle;
    end
    if (do_insert) begin
      entry_tag[win_idx]  <= tag_q;
      entry_comm[win_idx] <= comm_q;
    end
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      pay_mem[win_idx] <= '{count: count_q, dtype: dtype_q, buffer: buffer_q};
    end
    if (in_fire) begin
      rd_buffer <= pay_mem[slot[IDX_W-1:0]].buffer;
    end
  end

  `MTMT_ASSERT(a_occ_bound, $countones(entry_valid) >= occupied_count, "occupancy above valid count")
  `MTMT_ASSERT(a_ins_valid, do_insert |=> entry_valid[$past(win_idx)], "inserted slot not valid")
  `MTMT_ASSERT(a_clr_free, do_clear |=> !entry_valid[$past(slot_idx)], "cleared slot still valid")
  `MTMT_ASSERT_ALWAYS(a_one_busy, in_fire |=> !in_ready, "accepted while busy")

endmodule
`default_nettype wire
